// ----- sv/vrt_pkg.sv -----
// vrt_pkg: shared types and constants of the vertex rotate/translate/color core
// used by the channel interfaces, the row unit and the top level; no dependencies

package vrt_pkg;

  localparam int AXES     = 3;
  localparam int WORD_W   = 32;
  localparam int COEF_W   = 16;
  localparam int ROW_W    = AXES * COEF_W;
  localparam int PROD_W   = COEF_W + WORD_W;
  localparam int ACC_W    = PROD_W + 2;
  localparam int FRAC_SH  = 14;
  localparam int RND_W    = ACC_W - FRAC_SH;
  localparam int SUM_W    = RND_W + 1;
  localparam int COLOR_W  = SUM_W + 8;
  localparam int CFG_W    = 64;
  localparam int ADDR_W   = 6;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic [ROW_W-1:0]         row_t;
  typedef logic [AXES-1:0][WORD_W-1:0] vec_t;

  // register indexes on the configuration port
  typedef enum logic [2:0] {
    REG_ROT_ROW0 = 3'd0,
    REG_ROT_ROW1 = 3'd1,
    REG_ROT_ROW2 = 3'd2,
    REG_TRANS_X  = 3'd3,
    REG_TRANS_Y  = 3'd4,
    REG_TRANS_Z  = 3'd5
  } reg_idx_t;

  localparam row_t ROT_ROW0_RST = 48'h0000_0000_4000;
  localparam row_t ROT_ROW1_RST = 48'h0000_4000_0000;
  localparam row_t ROT_ROW2_RST = 48'h4000_0000_0000;

  // load enables of the four pipeline stages
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } stage_en_t;

endpackage

// ----- sv/vrt_in_if.sv -----
// vrt_in_if: input channel carrying one vertex position per transaction
// depends on vrt_pkg

interface vrt_in_if;
  import vrt_pkg::*;

  logic  valid;
  logic  ready;
  word_t pos_x;
  word_t pos_y;
  word_t pos_z;

  modport source (output valid, output pos_x, output pos_y, output pos_z, input ready);
  modport sink   (input valid, input pos_x, input pos_y, input pos_z, output ready);
endinterface

// ----- sv/vrt_out_if.sv -----
// vrt_out_if: result channel carrying transformed position and color
// depends on vrt_pkg

interface vrt_out_if;
  import vrt_pkg::*;

  logic              valid;
  logic              ready;
  word_t             out_x;
  word_t             out_y;
  word_t             out_z;
  logic [WORD_W-1:0] color_r;
  logic [WORD_W-1:0] color_g;
  logic [WORD_W-1:0] color_b;

  modport source (output valid, output out_x, output out_y, output out_z,
                  output color_r, output color_g, output color_b, input ready);
  modport sink   (input valid, input out_x, input out_y, input out_z,
                  input color_r, input color_g, input color_b, output ready);
endinterface

// ----- sv/vrt_row_unit.sv -----
// vrt_row_unit: four-stage datapath for one matrix row: multiply, sum,
// round plus translate, saturate plus color; depends on vrt_pkg

module vrt_row_unit (
  input  logic               clk,
  input  vrt_pkg::stage_en_t en,
  input  vrt_pkg::row_t      row,
  input  vrt_pkg::vec_t      pos,
  input  vrt_pkg::word_t     trans,
  output vrt_pkg::word_t     pos_o,
  output logic [31:0]        color_o
);
  import vrt_pkg::*;

  logic signed [PROD_W-1:0] prod_r   [AXES];
  logic signed [PROD_W-1:0] prod_nxt [AXES];
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic signed [ACC_W-1:0]  acc_rnd;
  logic signed [SUM_W-1:0]  sum_r, sum_nxt;
  logic [SUM_W-1:0]         mag;
  logic [COLOR_W-1:0]       color_full;
  word_t                    pos_r, pos_nxt;
  logic [WORD_W-1:0]        color_r, color_nxt;

  // stage 1: products of row entries and position components
  always_comb begin
    for (int j = 0; j < AXES; j++) begin
      prod_nxt[j] = PROD_W'($signed(row[COEF_W*j +: COEF_W]))
                  * PROD_W'($signed(pos[j]));
    end
  end

  // stage 2: exact row sum
  assign acc_nxt = ACC_W'(prod_r[0]) + ACC_W'(prod_r[1]) + ACC_W'(prod_r[2]);

  // stage 3: round to nearest, ties up, then add translation at full width
  assign acc_rnd = acc_r + ACC_W'(1 << (FRAC_SH - 1));
  assign sum_nxt = SUM_W'($signed(acc_rnd[ACC_W-1:FRAC_SH])) + SUM_W'(trans);

  // stage 4: signed saturation of the position, 255 * |sum| for color
  always_comb begin
    if (!sum_r[SUM_W-1] && (sum_r[SUM_W-2:WORD_W-1] != '0)) begin
      pos_nxt = {1'b0, {(WORD_W-1){1'b1}}};
    end else if (sum_r[SUM_W-1] && (sum_r[SUM_W-2:WORD_W-1] != '1)) begin
      pos_nxt = {1'b1, {(WORD_W-1){1'b0}}};
    end else begin
      pos_nxt = sum_r[WORD_W-1:0];
    end
    mag        = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);
    color_full = {mag, 8'h00} - COLOR_W'(mag);
    if (color_full[COLOR_W-1:WORD_W] != '0) begin
      color_nxt = '1;
    end else begin
      color_nxt = color_full[WORD_W-1:0];
    end
  end

  // payload registers, loaded by the stage enables
  always_ff @(posedge clk) begin
    if (en.s1) begin
      for (int j = 0; j < AXES; j++) prod_r[j] <= prod_nxt[j];
    end
    if (en.s2) acc_r <= acc_nxt;
    if (en.s3) sum_r <= sum_nxt;
    if (en.s4) begin
      pos_r   <= pos_nxt;
      color_r <= color_nxt;
    end
  end

  assign pos_o   = pos_r;
  assign color_o = color_r;
endmodule

// ----- sv/vertex_rotate_translate_color_core.sv -----
// vertex_rotate_translate_color_core: top level with configuration registers,
// pipeline valid control and three row units; depends on vrt_pkg, the channel
// interfaces and vrt_row_unit
//
// Usage: vertices arrive on in_if (pos_x/y/z, signed Q16.16) as valid/ready
// transactions. Each vertex gives exactly one result on out_if: the position
// M * v + t saturated to signed 32 bits, and color_r/g/b = 255 * |component|
// saturated to unsigned 32 bits.
// Pipeline: multiply, row sum, round and translate, saturate and color, each a
// register stage, lie between acceptance and out_if.valid. Throughput: one
// vertex per cycle unless out_if stalls; each row owns three multipliers.
// Stall: when out_if.ready is low, stages fill up behind the output register;
// in_if.ready drops only once every stage holds a vertex. Nothing is lost or
// repeated.
// Reset: rst_n low clears all stage valid bits and loads the identity matrix
// and a zero translation.
// Configuration: APB port, 64-bit data, register i at byte address 8*i;
// the user must write it only while the pipeline is empty (the block itself
// does not enforce this); reads return the value, zero-extended.

module vertex_rotate_translate_color_core (
  input  logic                      clk,
  input  logic                      rst_n,
  vrt_in_if.sink                    in_if,
  vrt_out_if.source                 out_if,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [vrt_pkg::ADDR_W-1:0] paddr,
  input  logic [vrt_pkg::CFG_W-1:0]  pwdata,
  output logic [vrt_pkg::CFG_W-1:0]  prdata,
  output logic                      pready
);
  import vrt_pkg::*;

  row_t      rot_r   [AXES];
  word_t     trans_r [AXES];
  reg_idx_t  cfg_idx;
  logic      cfg_wr;
  logic      v1_r, v2_r, v3_r, v4_r;
  stage_en_t en;
  vec_t      pos_in;
  word_t     pos_o   [AXES];
  logic [WORD_W-1:0] color_o [AXES];

  // configuration write decode
  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:3]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_r[0]   <= ROT_ROW0_RST;
      rot_r[1]   <= ROT_ROW1_RST;
      rot_r[2]   <= ROT_ROW2_RST;
      trans_r[0] <= '0;
      trans_r[1] <= '0;
      trans_r[2] <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_ROT_ROW0: rot_r[0]   <= pwdata[ROW_W-1:0];
        REG_ROT_ROW1: rot_r[1]   <= pwdata[ROW_W-1:0];
        REG_ROT_ROW2: rot_r[2]   <= pwdata[ROW_W-1:0];
        REG_TRANS_X:  trans_r[0] <= pwdata[WORD_W-1:0];
        REG_TRANS_Y:  trans_r[1] <= pwdata[WORD_W-1:0];
        REG_TRANS_Z:  trans_r[2] <= pwdata[WORD_W-1:0];
        default: ;
      endcase
    end
  end

  // configuration read
  always_comb begin
    case (cfg_idx)
      REG_ROT_ROW0: prdata = CFG_W'(rot_r[0]);
      REG_ROT_ROW1: prdata = CFG_W'(rot_r[1]);
      REG_ROT_ROW2: prdata = CFG_W'(rot_r[2]);
      REG_TRANS_X:  prdata = CFG_W'(unsigned'(trans_r[0]));
      REG_TRANS_Y:  prdata = CFG_W'(unsigned'(trans_r[1]));
      REG_TRANS_Z:  prdata = CFG_W'(unsigned'(trans_r[2]));
      default:      prdata = '0;
    endcase
  end

  // stage enables: a stage loads when it is empty or its content moves on
  assign en.s4 = !v4_r || out_if.ready;
  assign en.s3 = !v3_r || en.s4;
  assign en.s2 = !v2_r || en.s3;
  assign en.s1 = !v1_r || en.s2;
  assign in_if.ready = en.s1;

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en.s1) v1_r <= in_if.valid;
      if (en.s2) v2_r <= v1_r;
      if (en.s3) v3_r <= v2_r;
      if (en.s4) v4_r <= v3_r;
    end
  end

  assign pos_in = {in_if.pos_z, in_if.pos_y, in_if.pos_x};

  // one datapath per matrix row
  for (genvar i = 0; i < AXES; i++) begin : g_row
    vrt_row_unit u_row (
      .clk     (clk),
      .en      (en),
      .row     (rot_r[i]),
      .pos     (pos_in),
      .trans   (trans_r[i]),
      .pos_o   (pos_o[i]),
      .color_o (color_o[i])
    );
  end

  // result channel
  assign out_if.valid   = v4_r;
  assign out_if.out_x   = pos_o[0];
  assign out_if.out_y   = pos_o[1];
  assign out_if.out_z   = pos_o[2];
  assign out_if.color_r = color_o[0];
  assign out_if.color_g = color_o[1];
  assign out_if.color_b = color_o[2];
endmodule
